// ===== design/rfws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfws_pkg
// Shared types and constants for the rectangle fill write sequencer.
// ----------------------------------------------------------------------------
package rfws_pkg;

	localparam int MAX_DIM      = 4096;
	localparam int DIM_W        = $clog2(MAX_DIM) + 1;
	localparam int ADDR_W       = 32;
	localparam int PITCH_W      = 16;
	localparam int COLOR_W      = 16;
	localparam int WIDE_PIXELS  = 4;
	localparam int DATA_W       = WIDE_PIXELS * COLOR_W;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 32;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FRAME_BASE    = 3'd0,
		CFG_LINE_PITCH    = 3'd1,
		CFG_SCREEN_WIDTH  = 3'd2,
		CFG_SCREEN_HEIGHT = 3'd3,
		CFG_ROW_OFFSET    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic               kind;
		logic [DIM_W-1:0]   rect_x;
		logic [DIM_W-1:0]   rect_y;
		logic [DIM_W-1:0]   rect_width;
		logic [DIM_W-1:0]   rect_height;
		logic [COLOR_W-1:0] fill_color;
	} in_item_t;

	typedef struct packed {
		logic              accepted;
		logic              write_valid;
		logic [ADDR_W-1:0] write_address;
		logic              write_wide;
		logic [DATA_W-1:0] write_data;
		logic              last_write;
	} out_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  frame_base;
		logic [PITCH_W-1:0] line_pitch;
		logic [DIM_W-1:0]   screen_width;
		logic [DIM_W-1:0]   screen_height;
		logic [DIM_W-1:0]   row_offset;
	} cfg_regs_t;

	typedef struct packed {
		logic               busy;
		logic [DIM_W-1:0]   cursor_x;
		logic [DIM_W-1:0]   cursor_row;
		logic [DIM_W-1:0]   start_column;
		logic [DIM_W-1:0]   end_column;
		logic [DIM_W-1:0]   end_row;
		logic [COLOR_W-1:0] held_color;
	} fill_state_t;

endpackage

// ===== design/rfws_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfws_step
// Result and next fill state for one item: start check or next write.
// ----------------------------------------------------------------------------
module rfws_step import rfws_pkg::*; (
	input  in_item_t    item,
	input  fill_state_t state,
	input  cfg_regs_t   cfg,
	output out_item_t   res,
	output fill_state_t state_next
);

	localparam logic [DIM_W:0] STEP_WIDE = (DIM_W+1)'(WIDE_PIXELS);
	localparam logic [DIM_W:0] STEP_ONE  = (DIM_W+1)'(1);

	logic [DIM_W:0]         x_sum;
	logic [DIM_W:0]         y_sum;
	logic                   out_of_bounds;
	logic [DIM_W:0]         row_sum;
	logic [DIM_W+PITCH_W:0] row_product;
	logic [ADDR_W-1:0]      address;
	logic                   wide;
	logic [DIM_W:0]         next_x;
	logic [DIM_W:0]         next_row;
	logic                   row_done;
	logic                   last;

	assign x_sum = {1'b0, item.rect_x} + {1'b0, item.rect_width};
	assign y_sum = {1'b0, item.rect_y} + {1'b0, item.rect_height};
	assign out_of_bounds = (x_sum > {1'b0, cfg.screen_width})
		|| (y_sum > {1'b0, cfg.screen_height});

	assign row_sum     = {1'b0, state.cursor_row} + {1'b0, cfg.row_offset};
	assign row_product = row_sum * cfg.line_pitch;
	assign address     = cfg.frame_base + ADDR_W'(row_product)
		+ ADDR_W'({state.cursor_x, 1'b0});

	assign wide = (state.cursor_x[1:0] == 2'b00)
		&& (({1'b0, state.cursor_x} + STEP_WIDE) <= {1'b0, state.end_column});
	assign next_x   = {1'b0, state.cursor_x} + (wide ? STEP_WIDE : STEP_ONE);
	assign row_done = next_x >= {1'b0, state.end_column};
	assign next_row = {1'b0, state.cursor_row} + STEP_ONE;
	assign last     = row_done && (next_row >= {1'b0, state.end_row});

	always_comb begin
		res        = '0;
		state_next = state;
		if (item.kind == KIND_START) begin
			if (!state.busy && !out_of_bounds) begin
				res.accepted = 1'b1;
				if (item.rect_width != '0 && item.rect_height != '0) begin
					state_next.busy         = 1'b1;
					state_next.cursor_x     = item.rect_x;
					state_next.cursor_row   = item.rect_y;
					state_next.start_column = item.rect_x;
					state_next.end_column   = x_sum[DIM_W-1:0];
					state_next.end_row      = y_sum[DIM_W-1:0];
					state_next.held_color   = item.fill_color;
				end
			end
		end else if (state.busy) begin
			res.write_valid   = 1'b1;
			res.write_address = address;
			res.write_wide    = wide;
			res.write_data    = wide ? {WIDE_PIXELS{state.held_color}}
				: DATA_W'(state.held_color);
			res.last_write    = last;
			if (row_done) begin
				state_next.cursor_x   = state.start_column;
				state_next.cursor_row = next_row[DIM_W-1:0];
				if (last) begin
					state_next.busy = 1'b0;
				end
			end else begin
				state_next.cursor_x = next_x[DIM_W-1:0];
			end
		end
	end

endmodule

// ===== design/rectangle_fill_write_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_fill_write_sequencer
// Fill engine for an RGB565 frame buffer: one write at most per step item.
//
// Input channel item_valid / item_stall / item: a start item (kind 0) checks
// the rectangle against the screen and arms a fill; each step item (kind 1)
// while a fill runs yields its next halfword or aligned 64-bit write.
// Output channel result_valid / result_stall / result: exactly one result
// item per input item, in order.
// Configuration channel cfg_valid / cfg_ready / cfg_index / cfg_data: always
// ready; write only while no item is in flight.
// An item is registered in the input stage and its result in the output
// register. Rate: one item per cycle when not stalled, set by the step logic.
// Reset clears the configuration registers, the fill state and both stages.
// While result_stall is high the result holds, the input stage fills and
// item_stall rises only once that stage is also occupied.
// ----------------------------------------------------------------------------
module rectangle_fill_write_sequencer import rfws_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  in_item_t               item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output out_item_t              result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_regs_t   cfg_q;
	fill_state_t state_q;
	fill_state_t state_next;
	in_item_t    item_s1;
	logic        item_valid_s1;
	out_item_t   result_q;
	logic        result_valid_q;
	out_item_t   step_res;
	logic        advance;

	assign cfg_ready    = 1'b1;
	assign advance      = item_valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall   = item_valid_s1 && !advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAME_BASE:    cfg_q.frame_base    <= cfg_data[ADDR_W-1:0];
				CFG_LINE_PITCH:    cfg_q.line_pitch    <= cfg_data[PITCH_W-1:0];
				CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[DIM_W-1:0];
				CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[DIM_W-1:0];
				CFG_ROW_OFFSET:    cfg_q.row_offset    <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	rfws_step u_step (
		.item       (item_s1),
		.state      (state_q),
		.cfg        (cfg_q),
		.res        (step_res),
		.state_next (state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			state_q        <= state_next;
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= step_res;
		end
	end

	// a write always belongs to a running fill
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_res.write_valid) |-> state_q.busy)
		else $error("write issued with no fill running");

	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_res.last_write) |=> !state_q.busy)
		else $error("fill still running after its last write");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.accepted && result.write_valid))
		else $error("result both accepts a start and gives a write");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.busy |-> (state_q.cursor_x < state_q.end_column))
		else $error("cursor beyond the end of the row");

	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid_q && result_stall))
		else $error("input stalled while the output can move");

endmodule

// ===== sim/rectangle_fill_write_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_fill_write_sequencer_tb
// Self-checking bench for the rectangle fill engine. Start and step items go
// in through a valid/stall channel. A behavioural copy of the fill sequencing
// (bounds check, halfword and 64-bit write choice, address, last write)
// predicts one result for each accepted item. A checker compares each result
// field by field with the oldest prediction. The run covers directed corner
// cases, register settings from all-zero to all-ones, and random fills.
// Random idle bursts appear on both sides, and one long output hold-off
// makes the engine stall its input.
// ----------------------------------------------------------------------------
module rectangle_fill_write_sequencer_tb;
	import rfws_pkg::*;

	localparam int DIM_MAX         = (1 << DIM_W) - 1;
	localparam int HOLD_OFF_CYCLES = 40;
	localparam int DRAIN_CYCLES    = 8;
	localparam int TIMEOUT_NS      = 400_000;

	logic                   clk;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_stall;
	in_item_t               item;
	logic                   result_valid;
	logic                   result_stall;
	out_item_t              result;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// register copies
	logic [ADDR_W-1:0]  reg_base       = '0;
	logic [PITCH_W-1:0] reg_pitch      = '0;
	logic [DIM_W-1:0]   reg_width      = '0;
	logic [DIM_W-1:0]   reg_height     = '0;
	logic [DIM_W-1:0]   reg_row_offset = '0;

	// fill progress copies
	logic               fill_busy   = 1'b0;
	logic [DIM_W-1:0]   cur_x       = '0;
	logic [DIM_W-1:0]   cur_row     = '0;
	logic [DIM_W-1:0]   first_col   = '0;
	logic [DIM_W-1:0]   stop_col    = '0;
	logic [DIM_W-1:0]   stop_row    = '0;
	logic [COLOR_W-1:0] fill_colour = '0;

	out_item_t expected_outcomes[$];

	int  mismatch_count   = 0;
	int  items_sent       = 0;
	int  writes_seen      = 0;
	int  fills_started    = 0;
	bit  bursts_on        = 1'b1;
	bit  hold_off_pending = 1'b0;

	rectangle_fill_write_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d results outstanding", expected_outcomes.size());
		$display("end of test: mismatches");
		$finish;
	end

	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		mismatch_count++;
		$display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
	endtask

	task automatic predict_outcome(input in_item_t it);
		out_item_t   r;
		logic        wide;
		logic        row_done;
		logic        last;
		logic [31:0] next_x;
		r = '0;
		if (it.kind == KIND_START) begin
			if (!fill_busy
					&& 32'(it.rect_x) + 32'(it.rect_width) <= 32'(reg_width)
					&& 32'(it.rect_y) + 32'(it.rect_height) <= 32'(reg_height)) begin
				r.accepted = 1'b1;
				if (it.rect_width != 0 && it.rect_height != 0) begin
					fill_busy   = 1'b1;
					cur_x       = it.rect_x;
					cur_row     = it.rect_y;
					first_col   = it.rect_x;
					stop_col    = it.rect_x + it.rect_width;
					stop_row    = it.rect_y + it.rect_height;
					fill_colour = it.fill_color;
					fills_started++;
				end
			end
		end else if (fill_busy) begin
			wide     = (cur_x[1:0] == 2'b00) && (32'(cur_x) + 4 <= 32'(stop_col));
			next_x   = 32'(cur_x) + (wide ? WIDE_PIXELS : 1);
			row_done = next_x >= 32'(stop_col);
			last     = row_done && (32'(cur_row) + 1 >= 32'(stop_row));
			r.write_valid   = 1'b1;
			r.write_address = reg_base
				+ (32'(cur_row) + 32'(reg_row_offset)) * 32'(reg_pitch)
				+ 32'(cur_x) * 2;
			r.write_wide    = wide;
			r.write_data    = wide ? {WIDE_PIXELS{fill_colour}} : DATA_W'(fill_colour);
			r.last_write    = last;
			if (row_done) begin
				cur_x   = first_col;
				cur_row = cur_row + 1'b1;
				if (last)
					fill_busy = 1'b0;
			end else begin
				cur_x = next_x[DIM_W-1:0];
			end
		end
		expected_outcomes.push_back(r);
	endtask

	// caller stands just after a rising edge
	task automatic send_item(input in_item_t it);
		int gap;
		if (bursts_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 14);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
		predict_outcome(it);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_FRAME_BASE:    reg_base       = value[ADDR_W-1:0];
			CFG_LINE_PITCH:    reg_pitch      = value[PITCH_W-1:0];
			CFG_SCREEN_WIDTH:  reg_width      = value[DIM_W-1:0];
			CFG_SCREEN_HEIGHT: reg_height     = value[DIM_W-1:0];
			CFG_ROW_OFFSET:    reg_row_offset = value[DIM_W-1:0];
			default: ;
		endcase
	endtask

	// also pokes an index past the register list, which must be ignored
	task automatic load_settings(input logic [31:0] base, input logic [31:0] pitch,
		input logic [31:0] width, input logic [31:0] height, input logic [31:0] offset);
		logic [CFG_INDEX_W-1:0] spare;
		spare = CFG_INDEX_W'($urandom_range(int'(CFG_ROW_OFFSET) + 1,
			(1 << CFG_INDEX_W) - 1));
		write_register(spare, $urandom);
		write_register(CFG_FRAME_BASE, base);
		write_register(CFG_LINE_PITCH, pitch);
		write_register(CFG_SCREEN_WIDTH, width);
		write_register(CFG_SCREEN_HEIGHT, height);
		write_register(CFG_ROW_OFFSET, offset);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_settings();
		load_settings($urandom, $urandom,
			($urandom & 32'hFFFF_E000) | 32'($urandom_range(16, DIM_MAX)),
			($urandom & 32'hFFFF_E000) | 32'($urandom_range(16, DIM_MAX)),
			($urandom & 32'hFFFF_E000) | 32'($urandom_range(0, DIM_MAX)));
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
	endtask

	function automatic in_item_t random_payload();
		in_item_t it;
		it.kind        = 1'($urandom_range(0, 1));
		it.rect_x      = DIM_W'($urandom_range(0, DIM_MAX));
		it.rect_y      = DIM_W'($urandom_range(0, DIM_MAX));
		it.rect_width  = DIM_W'($urandom_range(0, DIM_MAX));
		it.rect_height = DIM_W'($urandom_range(0, DIM_MAX));
		it.fill_color  = COLOR_W'($urandom);
		return it;
	endfunction

	function automatic in_item_t rect_start(input int x, input int y, input int w,
		input int h, input int colour);
		in_item_t it;
		it.kind        = KIND_START;
		it.rect_x      = DIM_W'(x);
		it.rect_y      = DIM_W'(y);
		it.rect_width  = DIM_W'(w);
		it.rect_height = DIM_W'(h);
		it.fill_color  = COLOR_W'(colour);
		return it;
	endfunction

	function automatic in_item_t step_request();
		in_item_t it;
		it      = random_payload();
		it.kind = KIND_STEP;
		return it;
	endfunction

	// in-bounds start; mostly narrow, now and then one long row
	function automatic in_item_t fill_request(input int max_w);
		int x;
		int y;
		int w;
		int h;
		int span;
		int rows;
		span = max_w;
		rows = 3;
		if ($urandom_range(0, 19) == 0) begin
			span = 200;
			rows = 1;
		end
		x = $urandom_range(0, int'(reg_width) - 1);
		y = $urandom_range(0, int'(reg_height) - 1);
		w = $urandom_range(1, (int'(reg_width) - x < span) ? int'(reg_width) - x : span);
		h = $urandom_range(1, (int'(reg_height) - y < rows) ? int'(reg_height) - y : rows);
		if ($urandom_range(0, 9) == 0)
			w = 0;
		else if ($urandom_range(0, 9) == 0)
			h = 0;
		return rect_start(x, y, w, h, $urandom);
	endfunction

	task automatic test_reset_state();
		send_item(step_request());
		send_item(rect_start(0, 0, 0, 0, $urandom));
		send_item(rect_start(0, 0, 1, 1, $urandom));
	endtask

	task automatic test_corner_cases();
		send_item(rect_start(0, 0, 1, 1, 16'h0000));
		send_item(step_request());
		send_item(rect_start(DIM_MAX - 1, DIM_MAX - 1, 1, 1, 16'hFFFF));
		send_item(step_request());
		send_item(rect_start(DIM_MAX, 0, 1, 1, $urandom));
		send_item(rect_start(0, DIM_MAX, 1, 1, $urandom));
		send_item(rect_start(DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, 16'hFFFF));
		send_item(rect_start(3, 3, 0, 5, $urandom));
		send_item(rect_start(3, 3, 5, 0, $urandom));
		send_item(step_request());
		send_item(rect_start(1, 2, 8, 2, 16'hA5A5));
		send_item(step_request());
		send_item(rect_start(0, 0, 1, 1, $urandom));
		while (fill_busy)
			send_item(step_request());
	endtask

	task automatic test_random_fills(input int count, input int max_w);
		in_item_t it;
		int       sent;
		int       pick;
		bit       counts;
		sent = 0;
		while (sent < count || fill_busy) begin
			it   = random_payload();
			pick = $urandom_range(0, 99);
			if (fill_busy)
				it.kind = (pick < 4) ? KIND_START : KIND_STEP;
			else if (pick < 70)
				it = fill_request(max_w);
			else if (pick < 85) begin
				// keep any accepted fill small
				it.kind        = KIND_START;
				it.rect_width  = DIM_W'(int'(it.rect_width) % (max_w + 1));
				it.rect_height = DIM_W'(int'(it.rect_height) % 4);
			end else
				it.kind = KIND_STEP;
			counts = (it.kind == KIND_START) || fill_busy;
			send_item(it);
			if (counts)
				sent++;
		end
	endtask

	task automatic test_output_hold_off();
		bursts_on        = 1'b0;
		hold_off_pending = 1'b1;
		send_item(rect_start(0, 0, 64, 2, $urandom));
		while (fill_busy)
			send_item(step_request());
		settle();
		bursts_on = 1'b1;
	endtask

	initial begin
		int span;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
			end else if (bursts_on && $urandom_range(0, 5) == 0) begin
				span = $urandom_range(1, 14);
				result_stall <= 1'b1;
				repeat (span) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_outcomes.size() == 0) begin
				flag_mismatch("result with nothing expected", 64'(result.write_address),
					64'(0));
			end else begin
				want = expected_outcomes.pop_front();
				if (result.write_valid)
					writes_seen++;
				if (result.accepted !== want.accepted)
					flag_mismatch("accepted", 64'(result.accepted), 64'(want.accepted));
				if (result.write_valid !== want.write_valid)
					flag_mismatch("write_valid", 64'(result.write_valid),
						64'(want.write_valid));
				if (result.write_address !== want.write_address)
					flag_mismatch("write_address", 64'(result.write_address),
						64'(want.write_address));
				if (result.write_wide !== want.write_wide)
					flag_mismatch("write_wide", 64'(result.write_wide),
						64'(want.write_wide));
				if (result.write_data !== want.write_data)
					flag_mismatch("write_data", result.write_data, want.write_data);
				if (result.last_write !== want.last_write)
					flag_mismatch("last_write", 64'(result.last_write),
						64'(want.last_write));
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		settle();
		load_settings('1, '1, '1, '1, '1);
		test_corner_cases();
		settle();

		random_settings();
		test_random_fills(110, 24);
		settle();

		load_settings(32'h1000_0000, 32'd2560, 32'd1280, 32'd720, 32'd720);
		test_random_fills(110, 24);
		test_output_hold_off();

		load_settings(32'h0, 32'd32, 32'd16, 32'd16, 32'd0);
		test_random_fills(110, 16);
		settle();

		load_settings(32'hFFFF_F000, 32'hFFFF, DIM_MAX, DIM_MAX, 32'd0);
		test_random_fills(110, 24);
		settle();

		bursts_on = 1'b0;
		random_settings();
		test_random_fills(60, 24);
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d items: %0d fills armed, %0d frame buffer writes checked",
			items_sent, fills_started, writes_seen);
		$display("register sets from all-zero to all-ones, idle bursts and a long hold-off");
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/rfws_pkg.sv
design/rfws_step.sv
design/rectangle_fill_write_sequencer.sv
sim/rectangle_fill_write_sequencer_tb.sv
